/* rtl/core/skyline_rectangle_packer_assert.svh */
// Assertion macros for the skyline rectangle packer checker.
// Expects signals named clock and reset in the scope of use.
`ifndef SKYLINE_RECTANGLE_PACKER_ASSERT_SVH
`define SKYLINE_RECTANGLE_PACKER_ASSERT_SVH

// Checked outside reset only
`define SRP_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("skyline packer assertion failed");

// Checked at every edge, reset included
`define SRP_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("skyline packer assertion failed");

`endif

/* rtl/core/srp_pkg.sv */
// Shared constants, status codes and control types of the skyline packer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package srp_pkg;
   localparam int MAX_SEGMENTS_DEF = 256;
   localparam int COORD_BITS_DEF   = 13;
   localparam int DIM_BITS         = 13;
   localparam int POS_BITS         = 12;
   localparam int AREA_BITS        = 25;
   localparam int STATUS_BITS      = 3;
   localparam int CALC_BITS        = 18;
   localparam int CSR_ADDR_BITS    = 3;
   localparam int CSR_DATA_BITS    = 32;

   localparam logic [STATUS_BITS-1:0] ST_PLACED  = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_NO_FIT  = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_FULL    = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_ZERO    = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_CLEARED = 3'd4;

   localparam logic MODE_CLEAR = 1'b1;
   localparam logic REG_ATLAS_WIDTH  = 1'b0;
   localparam logic REG_ATLAS_HEIGHT = 1'b1;

   typedef struct packed {
      logic start;
      logic push;
      logic flush;
   } merge_ctl_type;

   function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v);
      if (v < 13'd3) return 13'd3;
      if (v > 13'd4096) return 13'd4096;
      return v;
   endfunction
endpackage
`default_nettype wire

/* rtl/core/srp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module srp_ram #(
   parameter int WIDTH = 39,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

/* rtl/core/srp_merge.sv */
// Write stage of the skyline rebuild: joins level neighbours and writes
// the new segment list in order. Depends on srp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module srp_merge #(
   parameter int MAX_SEGMENTS = srp_pkg::MAX_SEGMENTS_DEF,
   parameter int COORD_BITS   = srp_pkg::COORD_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire srp_pkg::merge_ctl_type            ctl,
   input  wire logic [3*COORD_BITS-1:0]           seg_in,
   output logic                                   wr_en,
   output logic [$clog2(MAX_SEGMENTS)-1:0]        wr_addr,
   output logic [3*COORD_BITS-1:0]                wr_data,
   output logic [$clog2(MAX_SEGMENTS+1)-1:0]      wr_count
);
   import srp_pkg::*;
   localparam int CB = COORD_BITS;
   localparam int AW = $clog2(MAX_SEGMENTS);
   localparam int CW = $clog2(MAX_SEGMENTS+1);

   logic [3*CB-1:0] pend_ff, pend_in;
   logic            pend_v_ff, pend_v_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            same_level;

   assign same_level = pend_ff[2*CB-1:CB] == seg_in[2*CB-1:CB];
   assign wr_addr    = cnt_ff[AW-1:0];
   assign wr_data    = pend_ff;
   assign wr_count   = cnt_ff;

   always_comb begin
      pend_in   = pend_ff;
      pend_v_in = pend_v_ff;
      cnt_in    = cnt_ff;
      wr_en     = 1'b0;
      priority if (ctl.start) begin
         pend_v_in = 1'b0;
         cnt_in    = '0;
      end else if (ctl.push) begin
         if (!pend_v_ff) begin
            pend_in   = seg_in;
            pend_v_in = 1'b1;
         end else if (same_level) begin
            pend_in[CB-1:0] = pend_ff[CB-1:0] + seg_in[CB-1:0];
         end else begin
            wr_en   = 1'b1;
            cnt_in  = cnt_ff + 1'b1;
            pend_in = seg_in;
         end
      end else if (ctl.flush && pend_v_ff) begin
         wr_en     = 1'b1;
         cnt_in    = cnt_ff + 1'b1;
         pend_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_v_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         pend_v_ff <= pend_v_in;
         cnt_ff    <= cnt_in;
      end
      pend_ff <= pend_in;
   end
endmodule
`default_nettype wire

/* rtl/core/skyline_rectangle_packer.sv */
// Place: each trial left edge passes S_FIT_W and S_HEAD, then S_BODY if it is
// not too wide, and S_BODY_W and S_BODY per further segment it spans (up to
// count*(count+1)/2 segment reads); a placement then passes S_DECIDE and copies
// each segment into the other RAM bank, then S_FLUSH and S_AREA end the rebuild.
// One request at a time; the single read port of the segment RAM sets the pace.
// Reset is synchronous; after it the S_INIT state rewrites the base segment.
`timescale 1ns / 1ps
`default_nettype none
module skyline_rectangle_packer #(
   parameter int MAX_SEGMENTS = srp_pkg::MAX_SEGMENTS_DEF,
   parameter int COORD_BITS   = srp_pkg::COORD_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_mode,
   input  wire logic [srp_pkg::DIM_BITS-1:0]        req_rect_width,
   input  wire logic [srp_pkg::DIM_BITS-1:0]        req_rect_height,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [srp_pkg::STATUS_BITS-1:0]          rsp_status,
   output logic [srp_pkg::POS_BITS-1:0]             rsp_x_pos,
   output logic [srp_pkg::POS_BITS-1:0]             rsp_y_pos,
   output logic [srp_pkg::AREA_BITS-1:0]            rsp_used_area,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [srp_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  wire logic [srp_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [srp_pkg::CSR_DATA_BITS-1:0]        csr_prdata,
   output logic                                     csr_pready
);
   import srp_pkg::*;
   localparam int CB = COORD_BITS;
   localparam int AW = $clog2(MAX_SEGMENTS);
   localparam int CW = $clog2(MAX_SEGMENTS+1);
   localparam int SW = 3*CB;

   typedef enum logic [10:0] {
      S_INIT   = 11'b00000000001,
      S_IDLE   = 11'b00000000010,
      S_FIT_W  = 11'b00000000100,
      S_HEAD   = 11'b00000001000,
      S_BODY_W = 11'b00000010000,
      S_BODY   = 11'b00000100000,
      S_DECIDE = 11'b00001000000,
      S_COPY_W = 11'b00010000000,
      S_COPY   = 11'b00100000000,
      S_FLUSH  = 11'b01000000000,
      S_AREA   = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;
   logic done_ff, done_in;

   logic [DIM_BITS-1:0]  aw_ff, ah_ff, aw_c, ah_c;
   logic [DIM_BITS-1:0]  wreq_ff, wreq_in, hreq_ff, hreq_in;
   logic                 bank_ff, bank_in, init_rsp_ff, init_rsp_in;
   logic [CW-1:0]        count_ff, count_in, i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [CW-1:0]        bidx_ff, bidx_in;
   logic [AREA_BITS-1:0] area_ff, area_in;
   logic [CB-1:0]        floor_ff, floor_in, sx_ff, sx_in, sw_ff, sw_in;
   logic [CB-1:0]        bw_ff, bw_in, bx_ff, bx_in, by_ff, by_in;
   logic signed [CALC_BITS-1:0] left_ff, left_in, left_n;
   logic [CALC_BITS-1:0] btop_ff, btop_in;
   logic                 found_ff, found_in, ins_ff, ins_in, clip_ff, clip_in;
   logic [AW-1:0]        rd_addr_ff, rd_addr_in;
   logic [2*DIM_BITS-1:0] prod_ff, prod_in;
   logic [STATUS_BITS-1:0] status_ff, status_in;

   logic [SW-1:0] rd0, rd1, rd_seg, base_seg, new_seg, merge_seg;
   logic [CB-1:0] rx, ry, rw, fl_n;
   logic [CALC_BITS-1:0] x_plus_w, fh, end_x, shrink;
   logic [AREA_BITS+1:0] area_sum;
   merge_ctl_type m_ctl;
   logic          m_we;
   logic [AW-1:0] m_addr;
   logic [SW-1:0] m_data;
   logic [CW-1:0] m_count;
   logic          we0, we1;
   logic [AW-1:0] wa;
   logic [SW-1:0] wd;
   logic          req_acc, rsp_free, cfg_wr;

   // configuration registers
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_ATLAS_HEIGHT) ? CSR_DATA_BITS'(ah_ff)
                                                         : CSR_DATA_BITS'(aw_ff);
   assign aw_c = clamp_dim(aw_ff);
   assign ah_c = clamp_dim(ah_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         aw_ff <= 13'd512;
         ah_ff <= 13'd512;
      end else if (cfg_wr) begin
         if (csr_paddr[2] == REG_ATLAS_WIDTH) begin
            aw_ff <= csr_pwdata[DIM_BITS-1:0];
         end else begin
            ah_ff <= csr_pwdata[DIM_BITS-1:0];
         end
      end
   end

   // segment store, two banks: the rebuild reads one and writes the other
   assign rd_seg = bank_ff ? rd1 : rd0;
   assign rx = rd_seg[3*CB-1:2*CB];
   assign ry = rd_seg[2*CB-1:CB];
   assign rw = rd_seg[CB-1:0];
   assign base_seg = {CB'(1), CB'(1), CB'(aw_c - 13'd2)};
   assign new_seg  = {bx_ff, CB'(CALC_BITS'(by_ff) + CALC_BITS'(hreq_ff)), CB'(wreq_ff)};

   assign we0 = (state_ff == S_INIT && !bank_ff) || (m_we && bank_ff);
   assign we1 = (state_ff == S_INIT &&  bank_ff) || (m_we && !bank_ff);
   assign wa  = (state_ff == S_INIT) ? '0 : m_addr;
   assign wd  = (state_ff == S_INIT) ? base_seg : m_data;

   srp_ram #(.WIDTH(SW), .DEPTH(MAX_SEGMENTS)) u_bank0 (
      .clock(clock), .wr_en(we0), .wr_addr(wa), .wr_data(wd),
      .rd_addr(rd_addr_ff), .rd_data(rd0));
   srp_ram #(.WIDTH(SW), .DEPTH(MAX_SEGMENTS)) u_bank1 (
      .clock(clock), .wr_en(we1), .wr_addr(wa), .wr_data(wd),
      .rd_addr(rd_addr_ff), .rd_data(rd1));

   srp_merge #(.MAX_SEGMENTS(MAX_SEGMENTS), .COORD_BITS(COORD_BITS)) u_merge (
      .clock(clock), .reset(reset), .ctl(m_ctl), .seg_in(merge_seg),
      .wr_en(m_we), .wr_addr(m_addr), .wr_data(m_data), .wr_count(m_count));

   // shared datapath terms
   assign x_plus_w = CALC_BITS'(rx) + CALC_BITS'(wreq_ff);
   assign fl_n     = (ry > floor_ff) ? ry : floor_ff;
   assign fh       = CALC_BITS'(fl_n) + CALC_BITS'(hreq_ff);
   assign left_n   = left_ff - $signed(CALC_BITS'(rw));
   assign end_x    = CALC_BITS'(bx_ff) + CALC_BITS'(CB'(wreq_ff));
   assign shrink   = end_x - CALC_BITS'(rx);
   assign area_sum = (AREA_BITS+2)'(area_ff) + (AREA_BITS+2)'(prod_ff);

   // hold off new requests while busy or while a finished result still waits for the slot
   assign req_stall = (state_ff != S_IDLE) || done_ff;
   assign req_acc   = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid || !rsp_stall;

   always_comb begin
      state_in = state_ff;   done_in = 1'b0;
      wreq_in = wreq_ff;     hreq_in = hreq_ff;
      bank_in = bank_ff;     init_rsp_in = init_rsp_ff;
      count_in = count_ff;   i_in = i_ff;   j_in = j_ff;   k_in = k_ff;
      bidx_in = bidx_ff;     area_in = area_ff;
      floor_in = floor_ff;   sx_in = sx_ff; sw_in = sw_ff;
      bw_in = bw_ff;         bx_in = bx_ff; by_in = by_ff;
      left_in = left_ff;     btop_in = btop_ff;
      found_in = found_ff;   ins_in = ins_ff; clip_in = clip_ff;
      rd_addr_in = rd_addr_ff;
      prod_in = prod_ff;     status_in = status_ff;
      m_ctl = '0;            merge_seg = rd_seg;

      unique case (state_ff)
         S_INIT: begin
            count_in = CW'(1);
            area_in  = '0;
            if (init_rsp_ff) begin
               status_in = ST_CLEARED;
               done_in   = 1'b1;
            end
            init_rsp_in = 1'b0;
            state_in    = S_IDLE;
         end
         S_IDLE: begin
            if (req_acc) begin
               wreq_in = req_rect_width;
               hreq_in = req_rect_height;
               if (req_mode == MODE_CLEAR) begin
                  init_rsp_in = 1'b1;
                  state_in    = S_INIT;
               end else if (req_rect_width == '0 || req_rect_height == '0) begin
                  status_in = ST_ZERO;
                  done_in   = 1'b1;
               end else begin
                  i_in = '0;  rd_addr_in = '0;  found_in = 1'b0;
                  btop_in = '1;  bw_in = '1;
                  state_in = S_FIT_W;
               end
            end
         end
         S_FIT_W:  state_in = S_HEAD;
         S_BODY_W: state_in = S_BODY;
         S_HEAD: begin
            sx_in = rx;  sw_in = rw;  floor_in = ry;  j_in = i_ff;
            left_in = $signed({1'b0, (CALC_BITS-1)'(wreq_ff)});
            if (x_plus_w > CALC_BITS'(aw_c - 13'd1)) begin
               i_in = i_ff + 1'b1;
               rd_addr_in = AW'(i_ff + 1'b1);
               state_in = (i_ff + 1'b1 == count_ff) ? S_DECIDE : S_FIT_W;
            end else begin
               state_in = S_BODY;
            end
         end
         S_BODY: begin
            if (j_ff >= count_ff || fh > CALC_BITS'(ah_c - 13'd1) || left_n <= 0) begin
               // this left edge is finished: record a fit if there is one
               if (j_ff < count_ff && fh <= CALC_BITS'(ah_c - 13'd1) &&
                   (fh < btop_ff || (fh == btop_ff && sw_ff < bw_ff))) begin
                  btop_in = fh;  bw_in = sw_ff;  bidx_in = i_ff;
                  bx_in = sx_ff; by_in = fl_n;   found_in = 1'b1;
               end
               i_in = i_ff + 1'b1;
               rd_addr_in = AW'(i_ff + 1'b1);
               state_in = (i_ff + 1'b1 == count_ff) ? S_DECIDE : S_FIT_W;
            end else begin
               floor_in = fl_n;
               left_in  = left_n;
               j_in     = j_ff + 1'b1;
               rd_addr_in = AW'(j_ff + 1'b1);
               state_in = S_BODY_W;
            end
         end
         S_DECIDE: begin
            prod_in = (2*DIM_BITS)'(wreq_ff) * (2*DIM_BITS)'(hreq_ff);
            if (!found_ff) begin
               status_in = ST_NO_FIT;
               done_in   = 1'b1;
               state_in  = S_IDLE;
            end else if (count_ff >= CW'(MAX_SEGMENTS)) begin
               status_in = ST_FULL;
               done_in   = 1'b1;
               state_in  = S_IDLE;
            end else begin
               k_in = '0;  rd_addr_in = '0;  ins_in = 1'b0;  clip_in = 1'b0;
               m_ctl.start = 1'b1;
               state_in = S_COPY_W;
            end
         end
         S_COPY_W: state_in = S_COPY;
         S_COPY: begin
            if (k_ff == count_ff) begin
               state_in = S_FLUSH;
            end else if (k_ff == bidx_ff && !ins_ff) begin
               // insert the new segment, then revisit the same entry
               merge_seg = new_seg;
               m_ctl.push = 1'b1;
               ins_in  = 1'b1;
               clip_in = 1'b1;
            end else begin
               if (clip_ff && CALC_BITS'(rx) < end_x) begin
                  if (shrink < CALC_BITS'(rw)) begin
                     merge_seg = {CB'(end_x), ry, CB'(CALC_BITS'(rw) - shrink)};
                     m_ctl.push = 1'b1;
                     clip_in = 1'b0;
                  end
               end else begin
                  m_ctl.push = 1'b1;
                  clip_in = 1'b0;
               end
               k_in = k_ff + 1'b1;
               rd_addr_in = AW'(k_ff + 1'b1);
               state_in = S_COPY_W;
            end
         end
         S_FLUSH: begin
            m_ctl.flush = 1'b1;
            state_in = S_AREA;
         end
         S_AREA: begin
            count_in = m_count;
            bank_in  = !bank_ff;
            area_in  = (area_sum > (AREA_BITS+2)'({AREA_BITS{1'b1}})) ? '1
                                                                   : AREA_BITS'(area_sum);
            status_in = ST_PLACED;
            done_in   = 1'b1;
            state_in  = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // result register; a finished result waits in done_ff until the slot is free
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_INIT;
         bank_ff     <= 1'b0;
         init_rsp_ff <= 1'b0;
         count_ff    <= CW'(1);
         area_ff     <= '0;
         done_ff     <= 1'b0;
         rsp_valid   <= 1'b0;
      end else begin
         state_ff    <= (done_ff && !rsp_free) ? state_ff : state_in;
         bank_ff     <= bank_in;
         init_rsp_ff <= init_rsp_in;
         count_ff    <= count_in;
         area_ff     <= area_in;
         if (done_ff && rsp_free) begin
            done_ff   <= 1'b0;
            rsp_valid <= 1'b1;
         end else begin
            done_ff <= done_ff || done_in;
            if (rsp_valid && !rsp_stall) begin
               rsp_valid <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!(done_ff && !rsp_free)) begin
         wreq_ff <= wreq_in;   hreq_ff <= hreq_in;
         i_ff <= i_in;         j_ff <= j_in;      k_ff <= k_in;
         bidx_ff <= bidx_in;   floor_ff <= floor_in;
         sx_ff <= sx_in;       sw_ff <= sw_in;
         bw_ff <= bw_in;       bx_ff <= bx_in;    by_ff <= by_in;
         left_ff <= left_in;   btop_ff <= btop_in;
         found_ff <= found_in; ins_ff <= ins_in;  clip_ff <= clip_in;
         rd_addr_ff <= rd_addr_in;
         prod_ff <= prod_in;   status_ff <= status_in;
      end
      if (done_ff && rsp_free) begin
         rsp_status    <= status_ff;
         rsp_x_pos     <= (status_ff == ST_PLACED) ? POS_BITS'(bx_ff) : '0;
         rsp_y_pos     <= (status_ff == ST_PLACED) ? POS_BITS'(by_ff) : '0;
         rsp_used_area <= area_ff;
      end
   end
endmodule
`default_nettype wire

/* rtl/core/srp_checker.sv */
// Port-level checks of the skyline packer, bound to the top level.
// Depends on srp_pkg and skyline_rectangle_packer_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "skyline_rectangle_packer_assert.svh"
module srp_port_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_valid,
   input wire logic                                req_stall,
   input wire logic                                req_mode,
   input wire logic [srp_pkg::DIM_BITS-1:0]        req_rect_width,
   input wire logic [srp_pkg::DIM_BITS-1:0]        req_rect_height,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_stall,
   input wire logic [srp_pkg::STATUS_BITS-1:0]     rsp_status,
   input wire logic [srp_pkg::POS_BITS-1:0]        rsp_x_pos,
   input wire logic [srp_pkg::POS_BITS-1:0]        rsp_y_pos,
   input wire logic [srp_pkg::AREA_BITS-1:0]       rsp_used_area,
   input wire logic                                csr_psel,
   input wire logic                                csr_penable,
   input wire logic                                csr_pwrite,
   input wire logic [srp_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input wire logic [srp_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   input wire logic [srp_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   input wire logic                                csr_pready
);
   import srp_pkg::*;

   `SRP_ASSERT(a_status_code, rsp_valid |-> (rsp_status == ST_PLACED || rsp_status == ST_NO_FIT || rsp_status == ST_FULL || rsp_status == ST_ZERO || rsp_status == ST_CLEARED))
   `SRP_ASSERT(a_unplaced_origin, rsp_valid && rsp_status != ST_PLACED |-> rsp_x_pos == '0 && rsp_y_pos == '0)
   `SRP_ASSERT(a_clear_area, rsp_valid && rsp_status == ST_CLEARED |-> rsp_used_area == '0)
   `SRP_ASSERT_ALWAYS(a_reset_quiet, reset |=> !rsp_valid)
endmodule

bind skyline_rectangle_packer srp_port_checker u_srp_checker (.*);
`default_nettype wire

/* bench/srp_checker.sv */
// Checker for the skyline rectangle packer: follows the register port, predicts
// every request's result and compares it with the response channel.
// Depends on srp_pkg for widths and status codes.
`timescale 1ns / 1ps
`default_nettype none
module srp_checker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   input  wire logic                              req_stall,
   input  wire logic                              req_mode,
   input  wire logic [srp_pkg::DIM_BITS-1:0]      req_rect_width,
   input  wire logic [srp_pkg::DIM_BITS-1:0]      req_rect_height,
   input  wire logic                              rsp_valid,
   input  wire logic                              rsp_stall,
   input  wire logic [srp_pkg::STATUS_BITS-1:0]   rsp_status,
   input  wire logic [srp_pkg::POS_BITS-1:0]      rsp_x_pos,
   input  wire logic [srp_pkg::POS_BITS-1:0]      rsp_y_pos,
   input  wire logic [srp_pkg::AREA_BITS-1:0]     rsp_used_area,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic                              csr_pready,
   input  wire logic [srp_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [srp_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output int                                     mismatches,
   output int                                     outstanding
);
   import srp_pkg::*;

   localparam int SEG_DEPTH = MAX_SEGMENTS_DEF;
   localparam int AREA_SAT  = (1 << AREA_BITS) - 1;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [POS_BITS-1:0]    x_pos;
      logic [POS_BITS-1:0]    y_pos;
      logic [AREA_BITS-1:0]   used_area;
   } placement_type;

   logic [COORD_BITS_DEF-1:0] seg_x [SEG_DEPTH];
   logic [COORD_BITS_DEF-1:0] seg_y [SEG_DEPTH];
   logic [COORD_BITS_DEF-1:0] seg_w [SEG_DEPTH];
   int                        seg_count;
   int                        area_sum;
   logic [DIM_BITS-1:0]       width_reg;
   logic [DIM_BITS-1:0]       height_reg;
   placement_type             placements_due [$];

   function automatic int bound_dim(input logic [DIM_BITS-1:0] v);
      if (v < 3) return 3;
      if (v > 4096) return 4096;
      return int'(v);
   endfunction

   task automatic restart_skyline();
      seg_x[0]  = 1;
      seg_y[0]  = 1;
      seg_w[0]  = COORD_BITS_DEF'(bound_dim(width_reg) - 2);
      seg_count = 1;
      area_sum  = 0;
   endtask

   // Floor of a rectangle whose left edge sits on segment idx, -1 where it cannot go
   function automatic int floor_at(input int idx, input int w, input int h);
      int aw;
      int ah;
      int fl;
      int left;
      int i;
      aw = bound_dim(width_reg);
      ah = bound_dim(height_reg);
      fl = int'(seg_y[idx]);
      left = w;
      i = idx;
      if (int'(seg_x[idx]) + w > aw - 1) return -1;
      while (left > 0) begin
         if (i >= seg_count) return -1;
         if (int'(seg_y[i]) > fl) fl = int'(seg_y[i]);
         if (fl + h > ah - 1) return -1;
         left -= int'(seg_w[i]);
         i++;
      end
      return fl;
   endfunction

   task automatic drop_segment(input int idx);
      for (int i = idx; i + 1 < seg_count; i++) begin
         seg_x[i] = seg_x[i+1];
         seg_y[i] = seg_y[i+1];
         seg_w[i] = seg_w[i+1];
      end
      seg_count--;
   endtask

   task automatic pack_request(input logic mode, input int w, input int h,
                               output placement_type r);
      int best_top;
      int best_w;
      int best_idx;
      int bx;
      int by;
      int fy;
      int i;
      int seg_end;
      int shrink;
      bit found;
      best_top = 32'h7FFF_FFFF;
      best_w = 32'h7FFF_FFFF;
      best_idx = 0;
      bx = 0;
      by = 0;
      found = 0;
      r = '0;
      if (mode == MODE_CLEAR) begin
         restart_skyline();
         r.status = ST_CLEARED;
         return;
      end
      r.used_area = AREA_BITS'(area_sum);
      if (w == 0 || h == 0) begin
         r.status = ST_ZERO;
         return;
      end
      for (i = 0; i < seg_count; i++) begin
         fy = floor_at(i, w, h);
         if (fy >= 0) begin
            if (fy + h < best_top || (fy + h == best_top && int'(seg_w[i]) < best_w)) begin
               best_top = fy + h;
               best_w = int'(seg_w[i]);
               best_idx = i;
               bx = int'(seg_x[i]);
               by = fy;
               found = 1;
            end
         end
      end
      if (!found) begin
         r.status = ST_NO_FIT;
         return;
      end
      if (seg_count >= SEG_DEPTH) begin
         r.status = ST_FULL;
         return;
      end
      for (i = seg_count; i > best_idx; i--) begin
         seg_x[i] = seg_x[i-1];
         seg_y[i] = seg_y[i-1];
         seg_w[i] = seg_w[i-1];
      end
      seg_x[best_idx] = COORD_BITS_DEF'(bx);
      seg_y[best_idx] = COORD_BITS_DEF'(by + h);
      seg_w[best_idx] = COORD_BITS_DEF'(w);
      seg_count++;
      // clip or drop the segments now under the new one
      i = best_idx + 1;
      while (i < seg_count) begin
         seg_end = int'(seg_x[i-1]) + int'(seg_w[i-1]);
         if (int'(seg_x[i]) < seg_end) begin
            shrink = seg_end - int'(seg_x[i]);
            if (shrink >= int'(seg_w[i])) begin
               drop_segment(i);
               continue;
            end
            seg_x[i] = COORD_BITS_DEF'(int'(seg_x[i]) + shrink);
            seg_w[i] = COORD_BITS_DEF'(int'(seg_w[i]) - shrink);
         end
         break;
      end
      i = 0;
      while (i + 1 < seg_count) begin
         if (seg_y[i] == seg_y[i+1]) begin
            seg_w[i] = seg_w[i] + seg_w[i+1];
            drop_segment(i + 1);
         end else begin
            i++;
         end
      end
      if (longint'(area_sum) + longint'(w) * longint'(h) > AREA_SAT) area_sum = AREA_SAT;
      else area_sum = area_sum + w * h;
      r.status = ST_PLACED;
      r.x_pos = POS_BITS'(bx);
      r.y_pos = POS_BITS'(by);
      r.used_area = AREA_BITS'(area_sum);
   endtask

   always @(posedge clock) begin
      placement_type due;
      if (reset) begin
         width_reg = 13'd512;
         height_reg = 13'd512;
         restart_skyline();
         placements_due.delete();
         mismatches = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == REG_ATLAS_WIDTH) width_reg = csr_pwdata[DIM_BITS-1:0];
            else height_reg = csr_pwdata[DIM_BITS-1:0];
         end
         if (req_valid && !req_stall) begin
            pack_request(req_mode, int'(req_rect_width), int'(req_rect_height), due);
            placements_due.push_back(due);
         end
         if (rsp_valid && !rsp_stall) begin
            if (placements_due.size() == 0) begin
               $error("response with no request outstanding");
               mismatches++;
            end else begin
               due = placements_due.pop_front();
               if (rsp_status !== due.status) begin
                  $error("status: expected %0d, got %0d", due.status, rsp_status);
                  mismatches++;
               end
               if (rsp_x_pos !== due.x_pos) begin
                  $error("x_pos: expected %0d, got %0d", due.x_pos, rsp_x_pos);
                  mismatches++;
               end
               if (rsp_y_pos !== due.y_pos) begin
                  $error("y_pos: expected %0d, got %0d", due.y_pos, rsp_y_pos);
                  mismatches++;
               end
               if (rsp_used_area !== due.used_area) begin
                  $error("used_area: expected %0d, got %0d", due.used_area, rsp_used_area);
                  mismatches++;
               end
            end
         end
      end
      outstanding = placements_due.size();
   end
endmodule
`default_nettype wire

/* bench/tb_skyline_rectangle_packer.sv */
// Top of the skyline packer testbench: clock, reset, register writes, request
// and response pacing, and the verdict. Depends on srp_pkg and srp_checker.
`timescale 1ns / 1ps
`default_nettype none
module tb_skyline_rectangle_packer;
   import srp_pkg::*;

   localparam int IDLE_LIMIT = 400000;
   localparam int REQS_PER_PHASE = 143;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_mode = 1'b0;
   logic [DIM_BITS-1:0]       req_rect_width = '0;
   logic [DIM_BITS-1:0]       req_rect_height = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [STATUS_BITS-1:0]    rsp_status;
   logic [POS_BITS-1:0]       rsp_x_pos;
   logic [POS_BITS-1:0]       rsp_y_pos;
   logic [AREA_BITS-1:0]      rsp_used_area;
   logic                      csr_psel = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0]  csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0]  csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0]  csr_prdata;
   logic                      csr_pready;
   int                        mismatches;
   int                        outstanding;
   int                        idle_cycles = 0;
   int                        atlas_w = 512;
   int                        atlas_h = 512;
   bit                        hold_rsp = 0;

   always #10 clock = ~clock;

   skyline_rectangle_packer dut (.*);

   srp_checker u_checker (
      .clock, .reset, .req_valid, .req_stall, .req_mode, .req_rect_width,
      .req_rect_height, .rsp_valid, .rsp_stall, .rsp_status, .rsp_x_pos,
      .rsp_y_pos, .rsp_used_area, .csr_psel, .csr_penable, .csr_pwrite,
      .csr_pready, .csr_paddr, .csr_pwdata, .mismatches, .outstanding
   );

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == IDLE_LIMIT) begin
            $display("tb_skyline_rectangle_packer: FAIL");
            $finish;
         end
      end
   end

   // Response pacing: calm stretches, short random stalls, rare long ones
   initial begin
      int n;
      bit calm;
      calm = 0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            repeat (400) @(posedge clock);
            hold_rsp = 0;
         end else if ($urandom_range(0, 199) == 0) begin
            calm = !calm;
         end else if (!calm && $urandom_range(0, 149) == 0) begin
            rsp_stall <= 1'b1;
            n = $urandom_range(20, 60);
            repeat (n) @(posedge clock);
         end else begin
            rsp_stall <= !calm && ($urandom_range(0, 3) == 0);
         end
      end
   end

   task automatic csr_write(input logic reg_sel, input int value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= CSR_ADDR_BITS'({reg_sel, 2'b00});
      csr_pwdata <= CSR_DATA_BITS'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (reg_sel == REG_ATLAS_WIDTH) atlas_w = value;
      else atlas_h = value;
   endtask

   task automatic send(input logic mode, input int w, input int h, input bit paced);
      int gap;
      req_valid <= 1'b1;
      req_mode <= mode;
      req_rect_width <= DIM_BITS'(w);
      req_rect_height <= DIM_BITS'(h);
      do @(posedge clock); while (req_stall);
      gap = 0;
      if (paced) begin
         if ($urandom_range(0, 29) == 0) gap = $urandom_range(20, 80);
         else if ($urandom_range(0, 3) == 0) gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic random_request();
      int pick;
      int wmax;
      int hmax;
      pick = $urandom_range(0, 99);
      wmax = (atlas_w / 6 > 1) ? atlas_w / 6 : 1;
      hmax = (atlas_h / 6 > 1) ? atlas_h / 6 : 1;
      if (pick < 3) send(MODE_CLEAR, $urandom_range(0, 4096), $urandom_range(0, 4096), 1);
      else if (pick < 6) send(!MODE_CLEAR, 0, $urandom_range(0, 4096), 1);
      else if (pick < 8) send(!MODE_CLEAR, $urandom_range(0, 4096), 0, 1);
      else if (pick < 12)
         send(!MODE_CLEAR, $urandom_range(1, 4096), $urandom_range(1, 4096), 1);
      else send(!MODE_CLEAR, $urandom_range(1, wmax), $urandom_range(1, hmax), 1);
   endtask

   initial begin
      int dims [8][2];
      dims = '{'{512, 512}, '{3, 3}, '{4096, 4096}, '{64, 40}, '{200, 1000},
               '{4096, 3}, '{3, 4096}, '{0, 0}};
      dims[7][0] = $urandom_range(3, 1500);
      dims[7][1] = $urandom_range(3, 1500);
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: borders, zero sizes, covering, width change without clear
      send(!MODE_CLEAR, 0, 5, 0);
      send(!MODE_CLEAR, 5, 0, 0);
      send(!MODE_CLEAR, 4096, 1, 0);
      send(!MODE_CLEAR, 1, 4096, 0);
      send(!MODE_CLEAR, 510, 1, 0);
      send(!MODE_CLEAR, 1, 510, 0);
      send(MODE_CLEAR, 8191 & 4096, 4095, 0);
      send(!MODE_CLEAR, 100, 50, 0);
      send(!MODE_CLEAR, 50, 80, 0);
      send(!MODE_CLEAR, 100, 30, 0);
      send(!MODE_CLEAR, 30, 30, 0);
      send(!MODE_CLEAR, 300, 10, 0);
      send(!MODE_CLEAR, 120, 20, 0);
      send(!MODE_CLEAR, 509, 400, 0);
      send(!MODE_CLEAR, 510, 1, 0);
      drain();
      csr_write(REG_ATLAS_WIDTH, 1024);
      send(!MODE_CLEAR, 600, 5, 0);
      send(MODE_CLEAR, 0, 0, 0);
      send(!MODE_CLEAR, 600, 5, 0);
      send(!MODE_CLEAR, 1022, 505, 0);
      drain();
      csr_write(REG_ATLAS_HEIGHT, 1);
      csr_write(REG_ATLAS_WIDTH, 8191);
      send(MODE_CLEAR, 0, 0, 0);
      send(!MODE_CLEAR, 4094, 1, 0);
      send(!MODE_CLEAR, 1, 2, 0);

      for (int p = 0; p < 8; p++) begin
         drain();
         csr_write(REG_ATLAS_WIDTH, dims[p][0]);
         csr_write(REG_ATLAS_HEIGHT, dims[p][1]);
         send(MODE_CLEAR, 0, 0, 1);
         if (p == 0) begin
            // hold the response side so the block backs up its input
            hold_rsp = 1;
            repeat (6) send(!MODE_CLEAR, $urandom_range(1, 60), $urandom_range(1, 60), 0);
         end
         repeat (REQS_PER_PHASE) random_request();
      end
      drain();
      repeat (40) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("tb_skyline_rectangle_packer: PASS");
      end else begin
         $display("tb_skyline_rectangle_packer: FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire
